@@ design/ssd_pkg.sv @@
// ============================================================================
// SDRAM size decoder package
// Shared geometry constants, field types and decode helpers.
// ============================================================================
package ssd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAN_W  = 21;
    localparam int unsigned BANK_W  = 22;
    localparam int unsigned ROW_W   = 5;
    localparam int unsigned COL_W   = 4;
    localparam int unsigned TYPE_W  = 5;
    localparam int unsigned VER_W   = 4;

    localparam logic [ROW_W-1:0]  ROW_BASE       = ROW_W'(13);
    localparam logic [ROW_W-1:0]  ROW_SHORT      = ROW_W'(12);
    localparam logic [2:0]        ROW_CODE_SHORT = 3'd7;
    localparam logic [COL_W-1:0]  COL_BASE       = COL_W'(9);
    localparam logic [2:0]        BANK_BASE      = 3'd3;
    localparam logic [5:0]        MB_SHIFT       = 6'd20;
    localparam logic [1:0]        BW_BASE        = 2'd2;
    localparam logic [1:0]        DBW_X16        = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_DDR4      = TYPE_W'(0);
    localparam logic [TYPE_W-1:0] TYPE_LPDDR5    = TYPE_W'(9);

    localparam logic [VER_W-1:0]  VER_ROW_HI     = VER_W'(2);
    localparam logic [VER_W-1:0]  VER_TYPE_EXT   = VER_W'(3);
    localparam logic [VER_W-1:0]  VER_NO_BG      = VER_W'(3);

    typedef logic [CHAN_W-1:0] t_chan_mb;
    typedef logic [BANK_W-1:0] t_bank_mb;

    // per-bank decode mode shared by both channels
    typedef struct packed {
        logic v2;
        logic lpddr5;
        logic bg_en;
    } t_geom_mode;

    // raw per-channel fields
    typedef struct packed {
        logic       rank2;
        logic [1:0] col0_f;
        logic [1:0] col1_f;
        logic       bank_bit;
        logic [1:0] row0_lo;
        logic [1:0] row1_lo;
        logic       row0_hi;
        logic       row1_hi;
        logic [1:0] bw_f;
        logic [1:0] dbw_f;
        logic       row34;
    } t_chan_fields;

    function automatic t_chan_fields pick_chan(
        input logic [WORD_W-1:0] w0,
        input logic [WORD_W-1:0] w1,
        input logic              chan
    );
        t_chan_fields f;
        logic [15:0]  half;
        half       = chan ? w0[31:16] : w0[15:0];
        f.rank2    = half[11];
        f.col0_f   = half[10:9];
        f.bank_bit = half[8];
        f.row0_lo  = half[7:6];
        f.row1_lo  = half[5:4];
        f.bw_f     = half[3:2];
        f.dbw_f    = half[1:0];
        f.row34    = chan ? w0[31] : w0[30];
        f.col1_f   = chan ? w1[3:2] : w1[1:0];
        f.row0_hi  = chan ? w1[7] : w1[5];
        f.row1_hi  = chan ? w1[6] : w1[4];
        return f;
    endfunction

    function automatic t_geom_mode decode_mode(
        input logic [WORD_W-1:0] w0,
        input logic [WORD_W-1:0] w1
    );
        t_geom_mode        m;
        logic [VER_W-1:0]  ver;
        logic [TYPE_W-1:0] dtype;
        ver   = w1[31:28];
        dtype = {2'b00, w0[15:13]};
        if (ver >= VER_TYPE_EXT) begin
            dtype = {w1[13:12], w0[15:13]};
        end
        m.v2     = (ver >= VER_ROW_HI);
        m.lpddr5 = (dtype == TYPE_LPDDR5);
        m.bg_en  = (dtype == TYPE_DDR4) && (ver != VER_NO_BG);
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] row_bits(
        input logic       hi,
        input logic [1:0] lo,
        input logic       v2
    );
        logic [2:0] code;
        code = v2 ? {hi, lo} : {1'b0, lo};
        return (code == ROW_CODE_SHORT) ? ROW_SHORT : ROW_BASE + ROW_W'(code);
    endfunction

endpackage

@@ design/ssd_chan.sv @@
// ============================================================================
// SDRAM size decoder - channel size
// Turns one channel's geometry fields into its size in MB.
// ============================================================================
module ssd_chan (
    input  ssd_pkg::t_geom_mode   i_mode,
    input  ssd_pkg::t_chan_fields i_fields,
    output ssd_pkg::t_chan_mb     o_size_mb
);
    import ssd_pkg::*;

    logic [ROW_W-1:0]  row0;
    logic [ROW_W-1:0]  row1;
    logic [COL_W-1:0]  col0;
    logic [COL_W-1:0]  col1;
    logic [2:0]        bank;
    logic [1:0]        bgrp;
    logic [1:0]        bw;
    logic [5:0]        exp_sum;
    logic [4:0]        exp_mb;
    logic [5:0]        diff;
    logic [3:0]        rank_sh;
    t_chan_mb          base;
    t_chan_mb          ranked;
    logic [CHAN_W+1:0] triple;

    always_comb begin
        row0 = row_bits(i_fields.row0_hi, i_fields.row0_lo, i_mode.v2);
        row1 = row_bits(i_fields.row1_hi, i_fields.row1_lo, i_mode.v2);
        col0 = COL_BASE + COL_W'(i_fields.col0_f);
        col1 = i_mode.v2 ? COL_BASE + COL_W'(i_fields.col1_f) : col0;
        bank = i_mode.lpddr5 ? BANK_BASE + 3'(i_fields.bank_bit)
                             : BANK_BASE - 3'(i_fields.bank_bit);
        if (i_mode.bg_en) begin
            bgrp = (i_fields.dbw_f == DBW_X16) ? 2'd2 : 2'd1;
        end else begin
            bgrp = 2'd0;
        end
        bw = BW_BASE >> i_fields.bw_f;

        // exponent stays within 3..18 for every field pattern
        exp_sum = 6'(row0) + 6'(col0) + 6'(bank) + 6'(bgrp) + 6'(bw);
        exp_mb  = 5'(exp_sum - MB_SHIFT);
        base    = t_chan_mb'(1) << exp_mb;

        // second rank: negative difference clamps to a full copy
        diff    = 6'(row0) - 6'(row1) + 6'(col0) - 6'(col1);
        rank_sh = diff[5] ? 4'd0 : diff[3:0];
        ranked  = i_fields.rank2 ? base + (base >> rank_sh) : base;

        triple  = (CHAN_W+2)'(ranked) + ((CHAN_W+2)'(ranked) << 1);
        o_size_mb = i_fields.row34 ? triple[CHAN_W+1:2] : ranked;
    end

endmodule

@@ design/sdram_size_decoder_top.sv @@
// ============================================================================
// SDRAM size decoder
// Decodes one bank's pair of geometry status words into channel and bank MB.
// ============================================================================
// One item is taken whenever start is high; busy is never raised, so an item
// can be offered every cycle. Its result appears on o_strobe for a single
// cycle: one register captures the words, one decode pass per channel feeds
// the result register. The receiver cannot stall, so each result must be
// taken in the cycle its strobe is high.
module sdram_size_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ssd_pkg::WORD_W-1:0]    i_status_word0,
    input  logic [ssd_pkg::WORD_W-1:0]    i_status_word1,
    output logic                          o_strobe,
    output logic [ssd_pkg::CHAN_W-1:0]    o_chan0_mb,
    output logic [ssd_pkg::CHAN_W-1:0]    o_chan1_mb,
    output logic [ssd_pkg::BANK_W-1:0]    o_bank_mb
);
    import ssd_pkg::*;

    logic              r_vld;
    logic [WORD_W-1:0] r_w0;
    logic [WORD_W-1:0] r_w1;
    logic              r_strobe;
    t_chan_mb          r_chan0_mb;
    t_chan_mb          r_chan1_mb;
    t_bank_mb          r_bank_mb;

    logic              n_vld;
    logic              n_strobe;
    t_chan_mb          n_chan0_mb;
    t_chan_mb          n_chan1_mb;
    t_bank_mb          n_bank_mb;

    t_geom_mode        mode;
    t_chan_fields      fields0;
    t_chan_fields      fields1;
    t_chan_mb          size0;
    t_chan_mb          size1;

    assign busy  = 1'b0;
    assign n_vld = start && !busy;

    assign mode    = decode_mode(r_w0, r_w1);
    assign fields0 = pick_chan(r_w0, r_w1, 1'b0);
    assign fields1 = pick_chan(r_w0, r_w1, 1'b1);

    ssd_chan u_chan0 (
        .i_mode    (mode),
        .i_fields  (fields0),
        .o_size_mb (size0)
    );

    ssd_chan u_chan1 (
        .i_mode    (mode),
        .i_fields  (fields1),
        .o_size_mb (size1)
    );

    // channel one only counts on dual-channel parts
    always_comb begin
        n_strobe   = r_vld;
        n_chan0_mb = size0;
        n_chan1_mb = r_w0[12] ? size1 : '0;
        n_bank_mb  = BANK_W'(n_chan0_mb) + BANK_W'(n_chan1_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_vld) begin
            r_w0 <= i_status_word0;
            r_w1 <= i_status_word1;
        end
        if (n_strobe) begin
            r_chan0_mb <= n_chan0_mb;
            r_chan1_mb <= n_chan1_mb;
            r_bank_mb  <= n_bank_mb;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_chan0_mb = r_chan0_mb;
    assign o_chan1_mb = r_chan1_mb;
    assign o_bank_mb  = r_bank_mb;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##2 o_strobe)
        else $error("item did not produce a result two cycles later");

    a_bank_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_bank_mb == BANK_W'(o_chan0_mb) + BANK_W'(o_chan1_mb)))
        else $error("bank total differs from channel sum");

    a_single_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_w0[12] |=> (o_chan1_mb == '0))
        else $error("channel one non-zero on single-channel item");

    a_chan0_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_chan0_mb != '0))
        else $error("channel zero size decoded as zero");
`endif

endmodule

@@ tb/tb_sdram_size_decoder_top.sv @@
// ============================================================================
// SDRAM size decoder testbench
// Sends pairs of geometry status words to the decoder: a directed set of
// corner cases first, then biased random pairs. A predictor works out the
// channel and bank sizes for each accepted pair, and every strobed result is
// checked field by field against the oldest outstanding prediction.
// ============================================================================
module tb_sdram_size_decoder_top;

    import ssd_pkg::*;

    localparam int RANDOM_PAIRS   = 400;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    localparam logic [VER_W-1:0]  VER_FIRST  = VER_W'(0);
    localparam logic [VER_W-1:0]  VER_ONE    = VER_W'(1);
    localparam logic [VER_W-1:0]  VER_LATE   = VER_W'(4);
    localparam logic [VER_W-1:0]  VER_TOP    = VER_W'(15);
    localparam logic [TYPE_W-1:0] TYPE_OTHER = TYPE_W'(3);
    localparam logic [TYPE_W-1:0] TYPE_TOP   = TYPE_W'(31);

    typedef struct {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } t_word_pair;

    typedef struct {
        t_chan_mb chan0;
        t_chan_mb chan1;
        t_bank_mb bank;
    } t_sizes;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [WORD_W-1:0] i_status_word0 = '0;
    logic [WORD_W-1:0] i_status_word1 = '0;
    logic              o_strobe;
    t_chan_mb          o_chan0_mb;
    t_chan_mb          o_chan1_mb;
    t_bank_mb          o_bank_mb;

    t_word_pair word_pairs_q[$];
    t_sizes     pending_sizes[$];

    bit offering = 1'b0;
    bit took     = 1'b0;
    bit timed_out = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int pairs_sent = 0;
    int sizes_checked = 0;
    int size_mismatches = 0;

    sdram_size_decoder_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_status_word0 (i_status_word0),
        .i_status_word1 (i_status_word1),
        .o_strobe       (o_strobe),
        .o_chan0_mb     (o_chan0_mb),
        .o_chan1_mb     (o_chan1_mb),
        .o_bank_mb      (o_bank_mb)
    );

    always #6 i_clk = ~i_clk;

    // size of one channel in MB
    function automatic t_chan_mb chan_size_mb(
        input logic [WORD_W-1:0] w0,
        input logic [WORD_W-1:0] w1,
        input bit                ch,
        input logic [VER_W-1:0]  ver,
        input logic [TYPE_W-1:0] dtype
    );
        logic [15:0] half;
        logic [31:0] mb;
        bit          v2;
        int          code0, code1, row0, row1, col0, col1;
        int          banks, grp, width, shamt;
        half  = ch ? w0[31:16] : w0[15:0];
        v2    = (ver >= VER_ROW_HI);
        col0  = int'(COL_BASE) + int'(half[10:9]);
        col1  = v2 ? int'(COL_BASE) + int'(ch ? w1[3:2] : w1[1:0]) : col0;
        code0 = int'(half[7:6]) + ((v2 && (ch ? w1[7] : w1[5])) ? 4 : 0);
        code1 = int'(half[5:4]) + ((v2 && (ch ? w1[6] : w1[4])) ? 4 : 0);
        row0  = (code0 == int'(ROW_CODE_SHORT)) ? int'(ROW_SHORT) : int'(ROW_BASE) + code0;
        row1  = (code1 == int'(ROW_CODE_SHORT)) ? int'(ROW_SHORT) : int'(ROW_BASE) + code1;
        banks = (dtype == TYPE_LPDDR5) ? int'(BANK_BASE) + int'(half[8])
                                       : int'(BANK_BASE) - int'(half[8]);
        width = int'(BW_BASE) >> half[3:2];
        grp   = 0;
        if (dtype == TYPE_DDR4 && ver != VER_NO_BG) begin
            grp = (half[1:0] == DBW_X16) ? 2 : 1;
        end
        mb = 32'd1 << (row0 + col0 + banks + grp + width - int'(MB_SHIFT));
        if (half[11]) begin
            // second rank: a smaller geometry adds a shifted copy, never more
            shamt = (row0 - row1) + (col0 - col1);
            if (shamt < 0) begin
                shamt = 0;
            end
            mb = mb + (mb >> shamt);
        end
        if (ch ? w0[31] : w0[30]) begin
            mb = (mb * 3) / 4;
        end
        return mb[CHAN_W-1:0];
    endfunction

    function automatic t_sizes decode_sizes(input logic [WORD_W-1:0] w0,
                                            input logic [WORD_W-1:0] w1);
        t_sizes            s;
        logic [VER_W-1:0]  ver;
        logic [TYPE_W-1:0] dtype;
        ver   = w1[31:28];
        dtype = {2'b00, w0[15:13]};
        if (ver >= VER_TYPE_EXT) begin
            dtype[4:3] = w1[13:12];
        end
        s.chan0 = chan_size_mb(w0, w1, 1'b0, ver, dtype);
        s.chan1 = w0[12] ? chan_size_mb(w0, w1, 1'b1, ver, dtype) : '0;
        s.bank  = t_bank_mb'(s.chan0) + t_bank_mb'(s.chan1);
        return s;
    endfunction

    // channel half layout: rank2, col[1:0], bank, row0lo[1:0], row1lo[1:0], bw[1:0], dbw[1:0]
    function automatic logic [WORD_W-1:0] make_word0(
        input logic [TYPE_W-1:0] dtype,
        input logic              dual,
        input logic              r34_0,
        input logic              r34_1,
        input logic [11:0]       h0,
        input logic [11:0]       h1
    );
        return {r34_1, r34_0, 2'b00, h1, dtype[2:0], dual, h0};
    endfunction

    // rowhi = {ch1 row0, ch1 row1, ch0 row0, ch0 row1}, col1 = {ch1, ch0}
    function automatic logic [WORD_W-1:0] make_word1(
        input logic [VER_W-1:0]  ver,
        input logic [TYPE_W-1:0] dtype,
        input logic [3:0]        rowhi,
        input logic [3:0]        col1
    );
        return {ver, 14'd0, dtype[4:3], 4'd0, rowhi, col1};
    endfunction

    task automatic queue_pair(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
        t_word_pair p;
        p.w0 = w0;
        p.w1 = w1;
        word_pairs_q.push_back(p);
    endtask

    // driver: offers the next item at the falling edge, may idle between items
    always @(negedge i_clk) begin
        t_word_pair p;
        int         r;
        if (i_rst_n) begin
            if (offering && took) begin
                offering = 1'b0;
            end
            if (!offering && gap_left > 0) begin
                gap_left--;
                i_status_word0 <= $urandom;
                i_status_word1 <= $urandom;
            end else if (!offering && word_pairs_q.size() != 0) begin
                p = word_pairs_q.pop_front();
                offering = 1'b1;
                i_status_word0 <= p.w0;
                i_status_word1 <= p.w1;
                if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
                    burst_left = $urandom_range(16, 40);
                end
                r = $urandom_range(0, 99);
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else if (r < 55) begin
                    gap_left = 0;
                end else if (r < 90) begin
                    gap_left = $urandom_range(1, 3);
                end else begin
                    gap_left = $urandom_range(8, 40);
                end
            end
            start <= offering;
        end
    end

    // monitor: records accepted items, checks strobed results, watches for stalls
    always @(posedge i_clk) begin
        t_sizes want;
        took = i_rst_n && start && !busy;
        if (took) begin
            pending_sizes.push_back(decode_sizes(i_status_word0, i_status_word1));
            pairs_sent++;
        end
        if (i_rst_n && o_strobe) begin
            if (pending_sizes.size() == 0) begin
                size_mismatches++;
                if (size_mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: chan0=%0d chan1=%0d bank=%0d",
                             o_chan0_mb, o_chan1_mb, o_bank_mb);
                end
            end else begin
                want = pending_sizes.pop_front();
                sizes_checked++;
                if (o_chan0_mb !== want.chan0 || o_chan1_mb !== want.chan1 ||
                    o_bank_mb !== want.bank) begin
                    size_mismatches++;
                    if (size_mismatches <= MAX_REPORTS) begin
                        $display("result %0d: chan0 %0d/%0d chan1 %0d/%0d bank %0d/%0d (exp/got)",
                                 sizes_checked, want.chan0, o_chan0_mb, want.chan1,
                                 o_chan1_mb, want.bank, o_bank_mb);
                    end
                end
            end
        end
        if (!i_rst_n || took || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
            end
        end
    end

    initial begin
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        int                r;

        // field extremes
        queue_pair('0, '0);
        queue_pair('1, '1);
        queue_pair('1, '0);
        queue_pair('0, '1);
        // DDR4, early version, single then dual with bank groups
        queue_pair(make_word0(TYPE_DDR4, 1'b0, 1'b0, 1'b0, 12'b0_00_0_00_00_00_10, '0),
                   make_word1(VER_FIRST, TYPE_DDR4, 4'b0000, 4'b0000));
        queue_pair(make_word0(TYPE_DDR4, 1'b1, 1'b0, 1'b0, 12'b1_11_1_11_11_00_10,
                              12'b1_10_0_01_00_01_01),
                   make_word1(VER_ONE, TYPE_DDR4, 4'b1111, 4'b1111));
        // row code 7 on row0 with rank 2: twelve rows and a negative shift
        queue_pair(make_word0(TYPE_OTHER, 1'b1, 1'b0, 1'b0, 12'b1_00_1_11_00_10_00,
                              12'b1_01_0_11_11_11_00),
                   make_word1(VER_ROW_HI, TYPE_OTHER, 4'b1110, 4'b0000));
        // rank-1 columns wider than rank 0: negative shift from the columns
        queue_pair(make_word0(TYPE_OTHER, 1'b1, 1'b0, 1'b0, 12'b1_00_0_01_01_01_00,
                              12'b1_01_0_10_10_00_00),
                   make_word1(VER_ROW_HI, TYPE_OTHER, 4'b0000, 4'b1111));
        // smallest size: twelve rows, nine columns, two bank bits, no width term
        queue_pair(make_word0(TYPE_OTHER, 1'b0, 1'b0, 1'b0, 12'b0_00_1_11_00_11_00, '0),
                   make_word1(VER_ROW_HI, TYPE_OTHER, 4'b0011, 4'b0000));
        // largest DDR4: row code 6, twelve columns, bank groups, rank 2 with no shift
        queue_pair(make_word0(TYPE_DDR4, 1'b1, 1'b0, 1'b0, 12'b1_11_0_10_10_00_10,
                              12'b1_11_0_10_10_00_10),
                   make_word1(VER_ROW_HI, TYPE_DDR4, 4'b1111, 4'b1111));
        // DDR4 at the extended-type version loses its bank groups
        queue_pair(make_word0(TYPE_DDR4, 1'b1, 1'b0, 1'b0, 12'b0_10_0_01_00_00_10,
                              12'b0_10_0_01_00_01_01),
                   make_word1(VER_NO_BG, TYPE_DDR4, 4'b0000, 4'b0000));
        // DDR4 after the extended-type version keeps them
        queue_pair(make_word0(TYPE_DDR4, 1'b1, 1'b0, 1'b0, 12'b0_01_0_10_00_00_10,
                              12'b0_01_1_00_00_10_11),
                   make_word1(VER_LATE, TYPE_DDR4, 4'b0000, 4'b0000));
        // LPDDR5: the bank bit adds a bank bit
        queue_pair(make_word0(TYPE_LPDDR5, 1'b1, 1'b0, 1'b0, 12'b0_11_1_10_00_00_00,
                              12'b1_11_1_10_10_01_00),
                   make_word1(VER_TYPE_EXT, TYPE_LPDDR5, 4'b1010, 4'b1111));
        queue_pair(make_word0(TYPE_LPDDR5, 1'b1, 1'b1, 1'b1, 12'b1_10_1_01_01_00_11,
                              12'b0_01_0_11_00_10_01),
                   make_word1(VER_LATE, TYPE_LPDDR5, 4'b0101, 4'b0110));
        // LPDDR5 low bits before the type extension: not LPDDR5
        queue_pair(make_word0(TYPE_LPDDR5, 1'b1, 1'b0, 1'b0, 12'b0_11_1_10_00_00_00,
                              12'b0_11_1_10_00_00_00),
                   make_word1(VER_ROW_HI, TYPE_LPDDR5, 4'b0000, 4'b0000));
        // widest type code at the top version
        queue_pair(make_word0(TYPE_TOP, 1'b1, 1'b0, 1'b1, 12'b1_01_1_01_10_11_11,
                              12'b1_10_1_00_01_11_11),
                   make_word1(VER_TOP, TYPE_TOP, 4'b0110, 4'b1001));
        // row 3/4 reduction: channel zero only, then a channel-one flag ignored
        queue_pair(make_word0(TYPE_OTHER, 1'b0, 1'b1, 1'b0, 12'b0_00_1_00_00_11_00, '0),
                   make_word1(VER_FIRST, TYPE_OTHER, 4'b0000, 4'b0000));
        queue_pair(make_word0(TYPE_OTHER, 1'b0, 1'b0, 1'b1, 12'b1_01_0_01_10_10_00,
                              12'b1_11_1_11_11_00_11),
                   make_word1(VER_ONE, TYPE_OTHER, 4'b1111, 4'b1111));
        // each bus-width field value
        queue_pair(make_word0(TYPE_DDR4, 1'b1, 1'b1, 1'b1, 12'b1_01_0_10_01_00_01,
                              12'b1_01_0_10_01_01_01),
                   make_word1(VER_ROW_HI, TYPE_DDR4, 4'b0101, 4'b0101));
        queue_pair(make_word0(TYPE_DDR4, 1'b1, 1'b1, 1'b0, 12'b1_01_0_10_01_10_00,
                              12'b1_01_0_10_01_11_00),
                   make_word1(VER_ROW_HI, TYPE_DDR4, 4'b1010, 4'b1010));

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            w0 = $urandom;
            w1 = $urandom;
            // keep most pairs in the versions that change the decode
            if ($urandom_range(0, 9) < 8) begin
                w1[31:28] = VER_W'($urandom_range(0, 4));
            end
            r = $urandom_range(0, 3);
            if (r == 0) begin
                w0[15:13] = TYPE_DDR4[2:0];
                w1[13:12] = TYPE_DDR4[4:3];
            end else if (r == 1) begin
                w0[15:13] = TYPE_LPDDR5[2:0];
                w1[13:12] = TYPE_LPDDR5[4:3];
                if ($urandom_range(0, 3) != 0) begin
                    w1[31:28] = VER_W'($urandom_range(VER_TYPE_EXT, 4));
                end
            end
            queue_pair(w0, w1);
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((word_pairs_q.size() != 0 || offering || pending_sizes.size() != 0) &&
               !timed_out) begin
            @(posedge i_clk);
        end
        if (!timed_out) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end else begin
            $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        end

        $display("Summary: %0d word pairs accepted, %0d results checked, %0d mismatches",
                 pairs_sent, sizes_checked, size_mismatches);
        $display("Covered DDR4/LPDDR5/other types, versions 0-4 and 15, short rows, ",
                 "negative rank shift, row 3/4 reduction");
        if (!timed_out && size_mismatches == 0 && pending_sizes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ssd_pkg.sv
design/ssd_chan.sv
design/sdram_size_decoder_top.sv
tb/tb_sdram_size_decoder_top.sv
